/* src/mftc_pkg.sv */
// Shared types and constants for the motor feedback travel counter.
// No dependencies; imported by motor_feedback_travel_counter.
`default_nettype none

package mftc_pkg;

  localparam int unsigned MotorCountDefault = 4;
  localparam logic [10:0] IdBase = 11'h200;
  localparam logic [3:0] FrameLength = 4'd8;

  localparam int unsigned InDataW = 80;
  localparam int unsigned OutDataW = 112;
  localparam int unsigned AddrW = 5;

  localparam logic [15:0] FullTurnReset = 16'd8191;
  localparam logic [15:0] GlitchLimitReset = 16'd7509;
  localparam logic [15:0] GlitchReplaceReset = 16'd68;
  localparam logic [31:0] TargetTravelReset = 32'd784534;
  localparam logic [15:0] RunSpeedReset = 16'd800;

  typedef enum logic [2:0] {
    REG_FULL_TURN      = 3'd0,
    REG_GLITCH_LIMIT   = 3'd1,
    REG_GLITCH_REPLACE = 3'd2,
    REG_TARGET_TRAVEL  = 3'd3,
    REG_RUN_SPEED      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]        angle;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic signed [7:0]  temperature;
  } motor_entry_t;

  typedef struct packed {
    logic [10:0] frame_id;
    logic        extended;
    logic [3:0]  length;
    logic [31:0] data_high;
    logic [31:0] data_low;
    logic        run;
  } frame_t;

  typedef struct packed {
    logic               updated;
    logic [1:0]         motor_index;
    motor_entry_t       motor;
    logic [31:0]        travelled;
    logic               speed_valid;
    logic signed [15:0] speed_setpoint;
    logic               done_res;
  } result_t;

endpackage

`default_nettype wire

/* src/motor_feedback_travel_counter.sv */
// Motor feedback travel counter: frame decode, motor store, travel accumulation.
// Depends on mftc_pkg.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  s_tdata (frame), s_tuser (extended)
//   m_*      out        m_tvalid/m_tready  m_tdata (result)
//   APB      in/out     psel/penable       paddr, pwdata, prdata (config)
//
// One transaction per cycle while m_tready does not stall; a result passes from the input
// register to the result register around one subtract, wrap, saturating add and target
// compare.
// Synchronous reset clears the store, travel state and config to defaults.
// A stall on m_tready holds the result register and backs up into the input register.
`default_nettype none

module motor_feedback_travel_counter
  import mftc_pkg::*;
#(
  parameter int unsigned MOTOR_COUNT = MotorCountDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output      logic                s_tready,
  // frame_id[10:0], length[14:11], data_high[46:15], data_low[78:47], run[79]
  input  wire logic [InDataW-1:0]  s_tdata,
  // extended[0]
  input  wire logic                s_tuser,
  output      logic                m_tvalid,
  input  wire logic                m_tready,
  // updated[0], motor_index[2:1], angle[18:3], speed[34:19], current[50:35],
  // temperature[58:51], travelled[90:59], speed_valid[91],
  // speed_setpoint[107:92], done_res[108], zero[111:109]
  output      logic [OutDataW-1:0] m_tdata,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrW-1:0]    paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready
);

  localparam int unsigned IdxW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam logic [10:0] IdLast = IdBase + 11'(MOTOR_COUNT);

  logic [15:0]        full_turn;
  logic [15:0]        glitch_limit;
  logic [15:0]        glitch_replace;
  logic [31:0]        target_travel;
  logic signed [15:0] run_speed;

  motor_entry_t motor_store [MOTOR_COUNT];
  logic [15:0]  previous_angle;
  logic         started;
  logic [31:0]  travel_sum;
  logic         finished;

  logic    in_valid;
  frame_t  in_frame;
  logic    out_valid;
  result_t out_result;
  logic    advance;
  logic    cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_turn      <= FullTurnReset;
      glitch_limit   <= GlitchLimitReset;
      glitch_replace <= GlitchReplaceReset;
      target_travel  <= TargetTravelReset;
      run_speed      <= RunSpeedReset;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(paddr[4:2]))
        REG_FULL_TURN:      full_turn      <= pwdata[15:0];
        REG_GLITCH_LIMIT:   glitch_limit   <= pwdata[15:0];
        REG_GLITCH_REPLACE: glitch_replace <= pwdata[15:0];
        REG_TARGET_TRAVEL:  target_travel  <= pwdata;
        REG_RUN_SPEED:      run_speed      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(paddr[4:2]))
      REG_FULL_TURN:      prdata = {16'd0, full_turn};
      REG_GLITCH_LIMIT:   prdata = {16'd0, glitch_limit};
      REG_GLITCH_REPLACE: prdata = {16'd0, glitch_replace};
      REG_TARGET_TRAVEL:  prdata = target_travel;
      REG_RUN_SPEED:      prdata = {16'd0, run_speed};
      default:            prdata = 32'd0;
    endcase
  end

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_frame.frame_id  <= s_tdata[10:0];
      in_frame.extended  <= s_tuser;
      in_frame.length    <= s_tdata[14:11];
      in_frame.data_high <= s_tdata[46:15];
      in_frame.data_low  <= s_tdata[78:47];
      in_frame.run       <= s_tdata[79];
    end
  end

  logic               match;
  logic [10:0]        slot;
  motor_entry_t       new_entry;
  motor_entry_t       motor0;
  logic               step_run;
  logic signed [16:0] delta;
  logic signed [17:0] wrapped;
  logic signed [17:0] step_delta;
  logic signed [33:0] sum_wide;
  logic [31:0]        travel_sum_next;
  logic               finished_next;
  logic [15:0]        previous_angle_next;
  logic               started_next;
  result_t            result_next;

  always_comb begin
    match = !in_frame.extended && (in_frame.length == FrameLength) &&
            (in_frame.frame_id > IdBase) && (in_frame.frame_id <= IdLast);
    slot = in_frame.frame_id - IdBase - 11'd1;
    new_entry.angle       = in_frame.data_high[31:16];
    new_entry.speed       = in_frame.data_high[15:0];
    new_entry.current     = in_frame.data_low[31:16];
    new_entry.temperature = in_frame.data_low[15:8];
    motor0 = (match && slot == 11'd0) ? new_entry : motor_store[0];

    step_run = in_frame.run && !finished;
    if (motor0.speed >= 0) begin
      delta = $signed({1'b0, motor0.angle}) - $signed({1'b0, previous_angle});
    end else begin
      delta = $signed({1'b0, previous_angle}) - $signed({1'b0, motor0.angle});
    end
    wrapped = 18'(delta) + $signed({2'b00, full_turn});
    if (delta < 0) begin
      step_delta = (wrapped >= $signed({2'b00, glitch_limit})) ?
                   $signed({2'b00, glitch_replace}) : wrapped;
    end else begin
      step_delta = 18'(delta);
    end
    sum_wide = $signed({2'b00, travel_sum}) + 34'(step_delta);

    previous_angle_next = previous_angle;
    started_next        = started;
    travel_sum_next     = travel_sum;
    finished_next       = finished;
    result_next.speed_valid    = 1'b0;
    result_next.speed_setpoint = 16'sd0;
    if (step_run) begin
      result_next.speed_valid    = 1'b1;
      result_next.speed_setpoint = run_speed;
      previous_angle_next        = motor0.angle;
      started_next               = 1'b1;
      if (started) begin
        if (sum_wide[33]) begin
          travel_sum_next = 32'd0;
        end else if (sum_wide[32]) begin
          travel_sum_next = 32'hFFFF_FFFF;
        end else begin
          travel_sum_next = sum_wide[31:0];
        end
        if (travel_sum_next >= target_travel) begin
          finished_next              = 1'b1;
          result_next.speed_setpoint = 16'sd0;
        end
      end
    end

    result_next.updated     = match;
    result_next.motor_index = match ? slot[1:0] : 2'd0;
    result_next.motor       = motor0;
    result_next.travelled   = travel_sum_next;
    result_next.done_res    = finished_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        motor_store[i] <= '0;
      end
      previous_angle <= 16'd0;
      started        <= 1'b0;
      travel_sum     <= 32'd0;
      finished       <= 1'b0;
    end else if (advance && in_valid) begin
      if (match) begin
        motor_store[slot[IdxW-1:0]] <= new_entry;
      end
      previous_angle <= previous_angle_next;
      started        <= started_next;
      travel_sum     <= travel_sum_next;
      finished       <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_result <= result_next;
    end
  end

  assign m_tdata = {3'd0,
                    out_result.done_res,
                    out_result.speed_setpoint,
                    out_result.speed_valid,
                    out_result.travelled,
                    out_result.motor.temperature,
                    out_result.motor.current,
                    out_result.motor.speed,
                    out_result.motor.angle,
                    out_result.motor_index,
                    out_result.updated};

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) finished |=> finished)
    else $error("finished latch dropped");
  assert property (@(posedge clk) disable iff (rst) finished |=> $stable(travel_sum))
    else $error("travel changed after finish");
  assert property (@(posedge clk) disable iff (rst) !started |=> travel_sum == 32'd0)
    else $error("travel accumulated before start angle");
  assert property (@(posedge clk) disable iff (rst) (in_valid && !advance) |=> in_valid)
    else $error("input register lost a frame during stall");
`endif

endmodule

`default_nettype wire
